FILE: rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg: shared constants for the label tag set store
// Operation codes, status codes and fixed field widths of the ports.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int IN_TAG_W = 64;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INS = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REM = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LKP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CMP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MRG = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLR = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

FILE: rtl/label_tag_set_store_top.sv
// ----------------------------------------------------------------------------
// label_tag_set_store_top: two bounded sets of security tags
// Insert, remove, lookup, subset compare, merge and clear on a selected set.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word: mode, set_sel, tag.
//   Result channel (out_valid / out_stall) returns exactly one word per input.
//   Only the low TAG_WIDTH bits of in_tag take part in any operation.
// Work per operation (one memory read per cycle while scanning):
//   insert / remove / lookup : one scan of the selected set.
//   compare / merge          : each valid entry of the other set is fetched
//                              and looked up with a full scan of the
//                              selected set.
//   clear and unused modes   : no scan; straight to the result.
//   One word is in work at a time; in_stall is high from acceptance until
//   the result is loaded into the output register.
// Reset (rst_n low, synchronous): both sets empty, output register empty.
//   The tag memory is not cleared; per-slot valid bits gate every read.
// Receiver stall: the finished result waits in the output register and the
//   next input word is still taken; a further result holds in its last
//   state until the output register frees up.
// ----------------------------------------------------------------------------
module label_tag_set_store_top
  import lts_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int TAG_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic                in_set_sel,
  input  logic [IN_TAG_W-1:0] in_tag,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_found,
  output logic [COUNT_W-1:0]  out_count,
  output logic                out_sel_dominates_other,
  output logic                out_other_dominates_sel
);

  localparam int SLOTS = 2 * CAPACITY;
  localparam int AW    = $clog2(SLOTS);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_POST   = 3'd2;
  localparam logic [2:0] S_OUTER  = 3'd3;
  localparam logic [2:0] S_OFETCH = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  // set s owns slots s*CAPACITY .. s*CAPACITY+CAPACITY-1
  function automatic logic [AW-1:0] slot_addr(input logic s, input logic [IDX_W-1:0] idx);
    logic [AW-1:0] base;
    base = s ? AW'(CAPACITY) : '0;
    return base + AW'(idx);
  endfunction

  // Control state
  logic [2:0]          state_r, state_nxt;
  logic [SLOTS-1:0]    vld_r, vld_nxt;
  logic [CW-1:0]       cnt0_r, cnt0_nxt;
  logic [CW-1:0]       cnt1_r, cnt1_nxt;
  logic                pv_r, pv_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Work registers
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic                sel_r, sel_nxt;
  logic [TAG_WIDTH-1:0] key_r, key_nxt;
  logic [CW-1:0]       scan_r, scan_nxt;
  logic [AW-1:0]       pa_r, pa_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic                hit_r, hit_nxt;
  logic [AW-1:0]       hit_a_r, hit_a_nxt;
  logic                free_ok_r, free_ok_nxt;
  logic [AW-1:0]       free_a_r, free_a_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic                found_r, found_nxt;
  logic                sdo_r, sdo_nxt;
  logic                ods_r, ods_nxt;

  // Output register payload
  logic [STATUS_W-1:0] out_status_r;
  logic                out_found_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_sdo_r;
  logic                out_ods_r;

  // Tag memory: one write port, one registered read port
  logic [TAG_WIDTH-1:0] mem [SLOTS];
  logic [TAG_WIDTH-1:0] mem_q;
  logic [AW-1:0]        rd_addr;
  logic                 we;

  logic                 accept;
  logic                 out_ld;
  logic [CW-1:0]        cnt_sel;
  logic [CW-1:0]        cnt_oth;
  logic [AW-1:0]        scan_addr;
  logic [AW-1:0]        outer_addr;
  logic                 proc_hit;
  logic                 proc_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_ld    = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  assign cnt_sel    = sel_r ? cnt1_r : cnt0_r;
  assign cnt_oth    = sel_r ? cnt0_r : cnt1_r;
  assign scan_addr  = slot_addr(sel_r, scan_r[IDX_W-1:0]);
  assign outer_addr = slot_addr(!sel_r, j_r[IDX_W-1:0]);
  assign rd_addr    = (state_r == S_OUTER) ? outer_addr : scan_addr;

  // compare stage of the scan: data for slot pa_r arrives this cycle
  assign proc_hit  = pv_r && vld_r[pa_r] && (mem_q == key_r);
  assign proc_free = pv_r && !vld_r[pa_r];

  always_comb begin
    state_nxt   = state_r;
    vld_nxt     = vld_r;
    cnt0_nxt    = cnt0_r;
    cnt1_nxt    = cnt1_r;
    pv_nxt      = pv_r;
    mode_nxt    = mode_r;
    sel_nxt     = sel_r;
    key_nxt     = key_r;
    scan_nxt    = scan_r;
    pa_nxt      = pa_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    hit_nxt     = hit_r;
    hit_a_nxt   = hit_a_r;
    free_ok_nxt = free_ok_r;
    free_a_nxt  = free_a_r;
    st_nxt      = st_r;
    found_nxt   = found_r;
    sdo_nxt     = sdo_r;
    ods_nxt     = ods_r;
    we          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt    = in_mode;
          sel_nxt     = in_set_sel;
          key_nxt     = in_tag[TAG_WIDTH-1:0];
          st_nxt      = ST_OK;
          found_nxt   = 1'b0;
          sdo_nxt     = 1'b0;
          ods_nxt     = 1'b0;
          j_nxt       = '0;
          k_nxt       = '0;
          scan_nxt    = '0;
          pv_nxt      = 1'b0;
          hit_nxt     = 1'b0;
          free_ok_nxt = 1'b0;
          unique case (in_mode) inside
            MODE_INS, MODE_REM, MODE_LKP: state_nxt = S_SCAN;
            MODE_CMP, MODE_MRG:           state_nxt = S_OUTER;
            MODE_CLR: begin
              if (in_set_sel) begin
                vld_nxt[SLOTS-1:CAPACITY] = '0;
                cnt1_nxt = '0;
              end else begin
                vld_nxt[CAPACITY-1:0] = '0;
                cnt0_nxt = '0;
              end
              state_nxt = S_FIN;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_SCAN: begin
        // issue stage
        if (scan_r < CW'(CAPACITY)) begin
          pv_nxt   = 1'b1;
          pa_nxt   = scan_addr;
          scan_nxt = scan_r + 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        // compare stage
        if (proc_hit) begin
          hit_nxt   = 1'b1;
          hit_a_nxt = pa_r;
        end
        if (proc_free && !free_ok_r) begin
          free_ok_nxt = 1'b1;
          free_a_nxt  = pa_r;
        end
        if ((scan_r == CW'(CAPACITY)) && !pv_r) begin
          state_nxt = S_POST;
        end
      end

      S_POST: begin
        state_nxt = S_FIN;
        case (mode_r)
          MODE_INS: begin
            if (hit_r) begin
              st_nxt    = ST_DUP;
              found_nxt = 1'b1;
            end else if (free_ok_r) begin
              we                = 1'b1;
              vld_nxt[free_a_r] = 1'b1;
              if (sel_r) cnt1_nxt = cnt1_r + 1'b1;
              else       cnt0_nxt = cnt0_r + 1'b1;
            end else begin
              st_nxt = ST_FULL;
            end
          end
          MODE_REM: begin
            if (hit_r) begin
              found_nxt        = 1'b1;
              vld_nxt[hit_a_r] = 1'b0;
              if (sel_r) cnt1_nxt = cnt1_r - 1'b1;
              else       cnt0_nxt = cnt0_r - 1'b1;
            end
          end
          MODE_LKP: found_nxt = hit_r;
          MODE_CMP: begin
            if (hit_r) k_nxt = k_r + 1'b1;
            j_nxt     = j_r + 1'b1;
            state_nxt = S_OUTER;
          end
          MODE_MRG: begin
            if (!hit_r) begin
              if (free_ok_r) begin
                we                = 1'b1;
                vld_nxt[free_a_r] = 1'b1;
                if (sel_r) cnt1_nxt = cnt1_r + 1'b1;
                else       cnt0_nxt = cnt0_r + 1'b1;
              end else begin
                st_nxt = ST_FULL;
              end
            end
            j_nxt     = j_r + 1'b1;
            state_nxt = S_OUTER;
          end
          default: state_nxt = S_FIN;
        endcase
      end

      S_OUTER: begin
        if (j_r == CW'(CAPACITY)) begin
          // sets hold distinct tags, so coverage is an intersection count
          if (mode_r == MODE_CMP) begin
            sdo_nxt = (k_r == cnt_oth);
            ods_nxt = (k_r == cnt_sel);
          end
          state_nxt = S_FIN;
        end else if (vld_r[outer_addr]) begin
          state_nxt = S_OFETCH;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      S_OFETCH: begin
        key_nxt     = mem_q;
        scan_nxt    = '0;
        pv_nxt      = 1'b0;
        hit_nxt     = 1'b0;
        free_ok_nxt = 1'b0;
        state_nxt   = S_SCAN;
      end

      S_FIN: begin
        if (out_ld) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      cnt0_r      <= '0;
      cnt1_r      <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      cnt0_r      <= cnt0_nxt;
      cnt1_r      <= cnt1_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    sel_r     <= sel_nxt;
    key_r     <= key_nxt;
    scan_r    <= scan_nxt;
    pa_r      <= pa_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    hit_r     <= hit_nxt;
    hit_a_r   <= hit_a_nxt;
    free_ok_r <= free_ok_nxt;
    free_a_r  <= free_a_nxt;
    st_r      <= st_nxt;
    found_r   <= found_nxt;
    sdo_r     <= sdo_nxt;
    ods_r     <= ods_nxt;
    if (out_ld) begin
      out_status_r <= st_r;
      out_found_r  <= found_r;
      out_count_r  <= COUNT_W'(cnt_sel);
      out_sdo_r    <= sdo_r;
      out_ods_r    <= ods_r;
    end
  end

  // tag memory; writes come only from S_POST, whose read data is never used
  always_ff @(posedge clk) begin
    if (we) mem[free_a_r] <= key_r;
    mem_q <= mem[rd_addr];
  end

  assign out_valid               = out_valid_r;
  assign out_status              = out_status_r;
  assign out_found               = out_found_r;
  assign out_count               = out_count_r;
  assign out_sel_dominates_other = out_sdo_r;
  assign out_other_dominates_sel = out_ods_r;

endmodule

FILE: sim/label_tag_set_store_top_test.sv
// ----------------------------------------------------------------------------
// label_tag_set_store_top_test: self-checking bench for the tag set store
// Drives insert, remove, lookup, compare, merge, clear and spare-mode words
// under random bursts and output stalls; a mirror of both sets predicts each
// result word, which is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module label_tag_set_store_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lts_pkg::*;

  localparam int CAP          = 16;
  localparam int TAG_W        = 64;
  localparam int CLK_HALF     = 6;
  localparam int RANDOM_WORDS = 1500;
  localparam int POOL_SIZE    = 24;
  // long receiver hold-off, started once enough words have gone in
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 600;
  // slowest operation is a compare or merge
  localparam int OP_WORST     = CAP * (CAP + 5) + 3;
  localparam int DRAIN_CYCLES = OP_WORST + 60;
  localparam int WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + OP_WORST + 16);

  localparam logic [IN_TAG_W-1:0] TAG_MASK = {IN_TAG_W{1'b1}} >> (IN_TAG_W - TAG_W);
  localparam logic [IN_TAG_W-1:0] TAG_ONES = {IN_TAG_W{1'b1}};

  // spare operation codes: the block must leave both sets alone
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  count;
    logic                sel_dom;
    logic                oth_dom;
  } tag_result_t;

  // --------------------------------------------------------------------------
  // Mirror of the two tag sets. note_word() applies an accepted input word
  // and queues the result word it must produce; check_word() pops the oldest
  // queued result and compares it with what came out.
  // --------------------------------------------------------------------------
  class tag_set_mirror;
    logic [IN_TAG_W-1:0] tag_mem [2][CAP];
    bit                  slot_used [2][CAP];
    tag_result_t         expected_words [$];
    int                  errors = 0;

    function int slot_of(int s, logic [IN_TAG_W-1:0] t);
      for (int i = 0; i < CAP; i++)
        if (slot_used[s][i] && tag_mem[s][i] == t) return i;
      return -1;
    endfunction

    function int size_of(int s);
      int n;
      n = 0;
      for (int i = 0; i < CAP; i++)
        if (slot_used[s][i]) n++;
      return n;
    endfunction

    // lowest free slot wins
    function bit store_tag(int s, logic [IN_TAG_W-1:0] t);
      for (int i = 0; i < CAP; i++) begin
        if (!slot_used[s][i]) begin
          slot_used[s][i] = 1'b1;
          tag_mem[s][i]   = t;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // every tag of set b is also in set a
    function bit holds_all(int a, int b);
      for (int i = 0; i < CAP; i++)
        if (slot_used[b][i] && slot_of(a, tag_mem[b][i]) < 0) return 1'b0;
      return 1'b1;
    endfunction

    function void note_word(logic [MODE_W-1:0] mode, logic sel, logic [IN_TAG_W-1:0] tag);
      tag_result_t r;
      int          me;
      int          other;
      int          slot;
      logic [IN_TAG_W-1:0] t;
      me     = int'(sel);
      other  = me ^ 1;
      t      = tag & TAG_MASK;
      r      = '0;
      r.status = ST_OK;
      case (mode)
        MODE_INS: begin
          if (slot_of(me, t) >= 0) begin
            r.found  = 1'b1;
            r.status = ST_DUP;
          end else if (!store_tag(me, t)) begin
            r.status = ST_FULL;
          end
        end
        MODE_REM: begin
          slot = slot_of(me, t);
          if (slot >= 0) begin
            r.found = 1'b1;
            slot_used[me][slot] = 1'b0;
          end
        end
        MODE_LKP: r.found = (slot_of(me, t) >= 0);
        MODE_CMP: begin
          r.sel_dom = holds_all(me, other);
          r.oth_dom = holds_all(other, me);
        end
        MODE_MRG: begin
          // other set's slot order; leftovers dropped once full
          for (int i = 0; i < CAP; i++)
            if (slot_used[other][i] && slot_of(me, tag_mem[other][i]) < 0)
              if (!store_tag(me, tag_mem[other][i])) r.status = ST_FULL;
        end
        MODE_CLR: begin
          for (int i = 0; i < CAP; i++) slot_used[me][i] = 1'b0;
        end
        default: ;
      endcase
      r.count = COUNT_W'(size_of(me));
      expected_words.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(tag_result_t got);
      tag_result_t want;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      want = expected_words.pop_front();
      check_field("status", 8'(want.status), 8'(got.status));
      check_field("found", 8'(want.found), 8'(got.found));
      check_field("count", 8'(want.count), 8'(got.count));
      check_field("sel_dominates_other", 8'(want.sel_dom), 8'(got.sel_dom));
      check_field("other_dominates_sel", 8'(want.oth_dom), 8'(got.oth_dom));
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode;
  logic                in_set_sel;
  logic [IN_TAG_W-1:0] in_tag;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic                out_found;
  logic [COUNT_W-1:0]  out_count;
  logic                out_sel_dominates_other;
  logic                out_other_dominates_sel;

  label_tag_set_store_top #(
    .CAPACITY  (CAP),
    .TAG_WIDTH (TAG_W)
  ) u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_mode                 (in_mode),
    .in_set_sel              (in_set_sel),
    .in_tag                  (in_tag),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_status              (out_status),
    .out_found               (out_found),
    .out_count               (out_count),
    .out_sel_dominates_other (out_sel_dominates_other),
    .out_other_dominates_sel (out_other_dominates_sel)
  );

  always #(CLK_HALF) clk = ~clk;

  tag_set_mirror       mirror;
  logic [IN_TAG_W-1:0] tag_pool [POOL_SIZE];
  int                  words_sent = 0;
  int                  burst_left = 0;
  bit                  steady     = 1'b0;   // no sender gaps while set

  // --------------------------------------------------------------------------
  // Sender. A word is held until accepted (valid high, stall low at the
  // edge). Bursts of back-to-back words are broken by random gaps, except
  // in steady stretches. valid is only lowered on the gap path, so a word
  // that follows in the same burst just swaps the payload.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [MODE_W-1:0] mode, input logic sel,
                           input logic [IN_TAG_W-1:0] tag);
    int gap;
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_set_sel <= sel;
    in_tag     <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mirror.note_word(mode, sel, tag);
    words_sent++;
    if (steady || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // mostly pool tags so that duplicates, hits and full sets are common
  function automatic logic [IN_TAG_W-1:0] pick_tag();
    if ($urandom_range(0, 6) == 0) return {$urandom, $urandom};
    return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int r = $urandom_range(0, 99);
    if (r < 30) return MODE_INS;
    if (r < 50) return MODE_REM;
    if (r < 68) return MODE_LKP;
    if (r < 80) return MODE_CMP;
    if (r < 90) return MODE_MRG;
    if (r < 95) return MODE_CLR;
    return $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver stall pattern: a style is picked for a random stretch (never,
  // light, heavy, alternating, periodic). Once, after HOLD_AT words, stall
  // is held high for HOLD_CYCLES so the output register and the work slot
  // both fill and in_stall backs up the sender.
  // --------------------------------------------------------------------------
  initial begin
    int   style;
    int   left;
    int   hold;
    bit   held;
    logic nxt;
    style     = 0;
    left      = 0;
    hold      = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_sent >= HOLD_AT) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end
      if (left == 0) begin
        style = $urandom_range(0, 4);
        left  = $urandom_range(20, 200);
      end else begin
        left--;
      end
      if (hold > 0) begin
        hold--;
        nxt = 1'b1;
      end else begin
        case (style)
          0:       nxt = 1'b0;
          1:       nxt = ($urandom_range(0, 3) == 0);
          2:       nxt = ($urandom_range(0, 3) != 0);
          3:       nxt = ~out_stall;
          default: nxt = ((left % 16) < 5);
        endcase
      end
      out_stall <= nxt;
    end
  end

  // result monitor: sample at the edge where the word is taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      mirror.check_word('{out_status, out_found, out_count,
                          out_sel_dominates_other, out_other_dominates_sel});
  end

  // watchdog: too long without any word moving on either channel
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int   kind;
    int   n;
    int   target;
    logic s;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_mode    = MODE_INS;
    in_set_sel = 1'b0;
    in_tag     = '0;
    mirror     = new();
    // pool: both extremes plus random tags
    tag_pool[0] = '0;
    tag_pool[1] = TAG_ONES;
    for (int i = 2; i < POOL_SIZE; i++) tag_pool[i] = {$urandom, $urandom};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed: extremes, every operation, edge cases ----
    send_word(MODE_INS, 1'b0, '0);
    send_word(MODE_INS, 1'b0, TAG_ONES);
    send_word(MODE_INS, 1'b0, '0);                         // duplicate
    send_word(MODE_LKP, 1'b0, '0);                         // hit
    send_word(MODE_LKP, 1'b0, 64'h5a5a_a5a5_0f0f_f0f0);    // miss
    send_word(MODE_REM, 1'b0, 64'h5a5a_a5a5_0f0f_f0f0);    // absent, still ok
    send_word(MODE_CMP, 1'b0, '0);                         // other set empty
    send_word(MODE_MRG, 1'b1, '0);                         // set 0 into set 1
    send_word(MODE_CMP, 1'b1, '0);                         // equal sets
    send_word(MODE_INS, 1'b1, 64'h8000_0000_0000_0001);
    send_word(MODE_CMP, 1'b0, TAG_ONES);                   // strict subset
    send_word(MODE_MRG, 1'b0, TAG_ONES);
    send_word(MODE_REM, 1'b0, '0);                         // present
    send_word(MODE_LKP, 1'b1, TAG_ONES);
    send_word(MODE_SPARE_LO, 1'b0, TAG_ONES);
    send_word(MODE_SPARE_HI, 1'b1, '0);
    send_word(MODE_CLR, 1'b1, TAG_ONES);
    send_word(MODE_CMP, 1'b1, '0);                         // selected empty
    send_word(MODE_CLR, 1'b0, '0);
    send_word(MODE_MRG, 1'b0, '0);                         // both empty

    // ---- random: well-formed sequences with random content, some noise ----
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      kind   = $urandom_range(0, 9);
      steady = ($urandom_range(0, 4) == 0);
      s      = 1'($urandom_range(0, 1));
      n      = $urandom_range(5, 22);
      case (kind)
        0, 1, 2: begin
          // fill toward full: hits the full-set and later overflow cases
          if ($urandom_range(0, 1)) send_word(MODE_CLR, s, pick_tag());
          repeat (n) send_word(MODE_INS, s, pick_tag());
        end
        3, 4, 5: begin
          repeat (n) send_word(pick_mode(), 1'($urandom_range(0, 1)), pick_tag());
        end
        6, 7: begin
          send_word(MODE_CMP, s, pick_tag());
          send_word(MODE_MRG, s, pick_tag());
          send_word(MODE_CMP, s, pick_tag());
          send_word(MODE_CMP, ~s, pick_tag());
          send_word(MODE_LKP, s, pick_tag());
        end
        8: begin
          // copy one set into the other, then break the equality
          send_word(MODE_CLR, s, pick_tag());
          send_word(MODE_MRG, s, pick_tag());
          send_word(MODE_CMP, s, pick_tag());
          send_word(MODE_REM, s, pick_tag());
          send_word(MODE_CMP, s, pick_tag());
          send_word(MODE_INS, s, pick_tag());
          send_word(MODE_CMP, ~s, pick_tag());
        end
        default: begin
          // noise: any code, any tag
          repeat (n) send_word(MODE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                               {$urandom, $urandom});
        end
      endcase
    end
    in_valid <= 1'b0;
    steady   = 1'b0;

    // drain, then give the block time to show any stray word
    while (mirror.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mirror.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
